@@ rtl/qsps_pkg.sv @@
// ----------------------------------------------------------------------------
// qsps_pkg: shared types and helpers for the query string pair splitter
// Result record, queue entry layout, character constants and hex decode.
// ----------------------------------------------------------------------------
package qsps_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_RESTART = 2'd1;
	localparam logic [1:0] KIND_PAIR    = 2'd2;
	localparam logic [1:0] KIND_STRING  = 2'd3;

	// characters with a meaning of their own
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] MAX_PAIR_RESET = 16'd255;

	// results one request can cause, and queue depth
	localparam int MAX_RES     = 4;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HEX  = 2'd2
	} esc_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       role;
		logic       had_eq;
	} res_t;

	typedef res_t [MAX_RES-1:0] res_list_t;

	typedef struct packed {
		res_list_t  res;
		logic [2:0] cnt;
	} entry_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data, logic role,
			logic had_eq);
		res_t r;
		r.kind   = kind;
		r.data   = data;
		r.role   = role;
		r.had_eq = had_eq;
		return r;
	endfunction

	// loose hex digit: digits map to 0..9, letters fold to lower case, rest wraps
	function automatic logic [7:0] hex_val(logic [7:0] c);
		logic [7:0] l;
		l = c;
		if (c >= 8'h30 && c <= 8'h39) begin
			return c - 8'h30;
		end
		if (c >= 8'h41 && c <= 8'h5A) begin
			l = c + 8'h20;
		end
		return l - 8'h61 + 8'd10;
	endfunction

endpackage

@@ rtl/qsps_char_if.sv @@
// ----------------------------------------------------------------------------
// qsps_char_if: raw character channel
// Valid/ready channel carrying one query string byte or the string end mark.
// ----------------------------------------------------------------------------
interface qsps_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_end;

	modport source (output valid, output in_byte, output in_end, input ready);
	modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

@@ rtl/qsps_res_if.sv @@
// ----------------------------------------------------------------------------
// qsps_res_if: result channel
// Valid/ready channel carrying one decoded byte, restart, pair end or string end.
// ----------------------------------------------------------------------------
interface qsps_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       out_role;
	logic       pair_had_equals;
	logic       last;

	modport source (output valid, output kind, output out_byte, output out_role,
		output pair_had_equals, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input out_role,
		input pair_had_equals, input last, output ready);
endinterface

@@ rtl/qsps_front.sv @@
// ----------------------------------------------------------------------------
// qsps_front: parser front end
// Tracks pair, segment and escape state and turns each request into a list
// of up to four results for the queue.
// ----------------------------------------------------------------------------
module qsps_front #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	qsps_char_if.sink           chars,
	input  logic                q_full,
	output logic                q_push,
	output qsps_pkg::entry_t    q_data
);
	import qsps_pkg::*;

	localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic [15:0]            max_pair_q;
	logic                   pair_open_q;
	logic                   in_value_q;
	esc_t                   esc_q;
	logic [7:0]             first_hex_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   po, iv;
	esc_t                   ep;
	logic [7:0]             fh;
	logic [COUNT_WIDTH-1:0] sc;
	res_list_t              lst;
	logic [2:0]             n;

	logic [LW-1:0] cfg_ext, mask_ext, lim, sc_ext;
	logic          cut;
	logic          accept;
	logic [7:0]    hex_hi, hex_lo;

	// decode both escape digits
	assign hex_hi = hex_val(first_hex_q);
	assign hex_lo = hex_val(chars.in_byte);

	// effective limit: zero acts as one, saturate at the counter range
	always_comb begin
		cfg_ext  = LW'(max_pair_q);
		mask_ext = LW'({COUNT_WIDTH{1'b1}});
		lim      = (cfg_ext == '0) ? LW'(1) : cfg_ext;
		if (lim > mask_ext) begin
			lim = mask_ext;
		end
		sc_ext = LW'(count_q);
		cut    = pair_open_q && (sc_ext >= lim);
	end

	// classify the request and build its result list
	always_comb begin
		po  = pair_open_q;
		iv  = in_value_q;
		ep  = esc_q;
		fh  = first_hex_q;
		sc  = count_q;
		lst = '0;
		n   = '0;
		if (chars.in_end) begin
			if (po) begin
				if (ep != ESC_NONE) begin
					lst[n[1:0]] = mk_res(KIND_DATA, CH_PCT, iv, 1'b0);
					n = n + 3'd1;
				end
				if (ep == ESC_HEX) begin
					lst[n[1:0]] = mk_res(KIND_DATA, fh, iv, 1'b0);
					n = n + 3'd1;
				end
				lst[n[1:0]] = mk_res(KIND_PAIR, 8'h00, 1'b0, iv);
				n = n + 3'd1;
			end
			lst[n[1:0]] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b0);
			n  = n + 3'd1;
			po = 1'b0;
			iv = 1'b0;
			ep = ESC_NONE;
			fh = '0;
			sc = '0;
		end else begin
			// close a full pair before this byte
			if (cut) begin
				if (ep != ESC_NONE) begin
					lst[n[1:0]] = mk_res(KIND_DATA, CH_PCT, iv, 1'b0);
					n = n + 3'd1;
				end
				if (ep == ESC_HEX) begin
					lst[n[1:0]] = mk_res(KIND_DATA, fh, iv, 1'b0);
					n = n + 3'd1;
				end
				lst[n[1:0]] = mk_res(KIND_PAIR, 8'h00, 1'b0, iv);
				n  = n + 3'd1;
				po = 1'b0;
			end
			if (!po) begin
				po = 1'b1;
				iv = 1'b0;
				ep = ESC_NONE;
				sc = '0;
			end
			if (chars.in_byte == CH_AMP || chars.in_byte == CH_EQ) begin
				// segment end: emit a cut-short escape literally
				if (ep != ESC_NONE) begin
					lst[n[1:0]] = mk_res(KIND_DATA, CH_PCT, iv, 1'b0);
					n = n + 3'd1;
				end
				if (ep == ESC_HEX) begin
					lst[n[1:0]] = mk_res(KIND_DATA, fh, iv, 1'b0);
					n = n + 3'd1;
				end
				ep = ESC_NONE;
				if (chars.in_byte == CH_AMP) begin
					lst[n[1:0]] = mk_res(KIND_PAIR, 8'h00, 1'b0, iv);
					n  = n + 3'd1;
					po = 1'b0;
					iv = 1'b0;
					sc = '0;
				end else begin
					if (iv) begin
						lst[n[1:0]] = mk_res(KIND_RESTART, 8'h00, 1'b1, 1'b0);
						n = n + 3'd1;
					end
					iv = 1'b1;
					sc = sc + COUNT_WIDTH'(1);
				end
			end else begin
				sc = sc + COUNT_WIDTH'(1);
				case (ep)
					ESC_PCT: begin
						fh = chars.in_byte;
						ep = ESC_HEX;
					end
					ESC_HEX: begin
						lst[n[1:0]] = mk_res(KIND_DATA,
							{hex_hi[3:0], 4'h0} | hex_lo, iv, 1'b0);
						n  = n + 3'd1;
						ep = ESC_NONE;
					end
					default: begin
						if (chars.in_byte == CH_PCT) begin
							ep = ESC_PCT;
						end else if (chars.in_byte == CH_PLUS) begin
							lst[n[1:0]] = mk_res(KIND_DATA, CH_SPACE, iv, 1'b0);
							n = n + 3'd1;
						end else begin
							lst[n[1:0]] = mk_res(KIND_DATA, chars.in_byte, iv, 1'b0);
							n = n + 3'd1;
						end
					end
				endcase
			end
		end
	end

	assign chars.ready = !q_full;
	assign accept      = chars.valid && !q_full;
	assign q_push      = accept && (n != 3'd0);
	assign q_data.res  = lst;
	assign q_data.cnt  = n;

	// hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pair_q <= MAX_PAIR_RESET;
		end else if (cfg_we) begin
			max_pair_q <= cfg_wdata;
		end
	end

	// advance parser state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_open_q <= 1'b0;
			in_value_q  <= 1'b0;
			esc_q       <= ESC_NONE;
			first_hex_q <= '0;
			count_q     <= '0;
		end else if (accept) begin
			pair_open_q <= po;
			in_value_q  <= iv;
			esc_q       <= ep;
			first_hex_q <= fh;
			count_q     <= sc;
		end
	end

endmodule

@@ rtl/qsps_queue.sv @@
// ----------------------------------------------------------------------------
// qsps_queue: result list queue
// Small register FIFO between the front end and the output serializer.
// ----------------------------------------------------------------------------
module qsps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qsps_pkg::entry_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output qsps_pkg::entry_t head
);
	import qsps_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// store pushed lists
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/qsps_back.sv @@
// ----------------------------------------------------------------------------
// qsps_back: output serializer
// Walks the head list of the queue and presents its results one at a time.
// ----------------------------------------------------------------------------
module qsps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  qsps_pkg::entry_t q_head,
	output logic             q_pop,
	qsps_res_if.source       results
);
	import qsps_pkg::*;

	logic [1:0] idx_q;
	logic       is_last;
	logic       take;
	res_t       cur;

	assign cur     = q_head.res[idx_q];
	assign is_last = ({1'b0, idx_q} + 3'd1) == q_head.cnt;
	assign take    = !q_empty && results.ready;
	assign q_pop   = take && is_last;

	// drive the current result
	assign results.valid           = !q_empty;
	assign results.kind            = cur.kind;
	assign results.out_byte        = cur.data;
	assign results.out_role        = cur.role;
	assign results.pair_had_equals = cur.had_eq;
	assign results.last            = is_last;

	// step through the list, rewind on the final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

@@ rtl/query_string_pair_splitter.sv @@
// A request's result list is pushed into the queue and offered once it reaches the head.
// The block takes one request per cycle while each causes at most one result and
// the receiver is ready; a request with several results is presented one result at a
// time, and a four-entry queue lets the front keep taking requests meanwhile.
// Reset: arst_n clears parser state and the queue, and sets the pair limit to 255.
// ----------------------------------------------------------------------------
// query_string_pair_splitter: query string pair splitter with percent decode
// Splits a byte stream into key/value pairs and decodes escapes on the fly.
// ----------------------------------------------------------------------------
module query_string_pair_splitter #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	qsps_char_if.sink   chars,
	qsps_res_if.source  results
);
	import qsps_pkg::*;

	logic   q_full, q_empty, q_push, q_pop;
	entry_t q_in, q_head;

	qsps_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.chars    (chars),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	qsps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	qsps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.results(results)
	);

endmodule

@@ sim/tb_query_string_pair_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_query_string_pair_splitter: self-checking bench for the pair splitter
// Streams directed and random query strings through the character channel
// under several pair length limits. A scoreboard works out the decoded bytes,
// restarts, pair ends and string ends of every accepted request, and checks
// each result field by field. Both sides idle at random, and one long
// receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_query_string_pair_splitter;
	import qsps_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	// receiver behavior
	localparam int RDY_ALWAYS  = 0;
	localparam int RDY_RANDOM  = 1;
	localparam int RDY_PATTERN = 2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       role;
		logic       had_eq;
		logic       last;
	} token_t;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} char_req_t;

	// Tracks parser state and holds the results each request should cause.
	class pair_scoreboard;
		logic [15:0] pair_limit;
		bit          pair_open;
		bit          in_value;
		esc_t        esc_phase;
		logic [7:0]  first_hex;
		logic [15:0] stored;
		token_t      expected_q[$];
		token_t      step_q[$];
		int errors, requests, results;
		int pair_ends, cuts, restarts, string_ends, short_escapes;

		function new();
			pair_limit = MAX_PAIR_RESET;
			pair_open  = 0;
			in_value   = 0;
			esc_phase  = ESC_NONE;
			first_hex  = '0;
			stored     = '0;
		endfunction

		function void set_limit(logic [15:0] v);
			pair_limit = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [7:0] digit_value(logic [7:0] c);
			logic [7:0] folded;
			folded = (c inside {[CH_UP_A:CH_UP_Z]}) ? (c | 8'h20) : c;
			return (c inside {[CH_ZERO:CH_NINE]}) ? c - CH_ZERO : folded - CH_LOW_A + 8'd10;
		endfunction

		function void emit(logic [1:0] k, logic [7:0] d, logic r, logic eq);
			token_t t;
			t.kind   = k;
			t.data   = d;
			t.role   = r;
			t.had_eq = eq;
			t.last   = 1'b0;
			step_q.push_back(t);
		endfunction

		// emit a cut-short escape literally
		function void flush_escape();
			if (esc_phase == ESC_PCT) begin
				emit(KIND_DATA, CH_PCT, in_value, 1'b0);
				short_escapes++;
			end else if (esc_phase == ESC_HEX) begin
				emit(KIND_DATA, CH_PCT, in_value, 1'b0);
				emit(KIND_DATA, first_hex, in_value, 1'b0);
				short_escapes++;
			end
			esc_phase = ESC_NONE;
		endfunction

		function void close_pair();
			flush_escape();
			emit(KIND_PAIR, 8'h00, 1'b0, in_value);
			pair_open = 0;
			in_value  = 0;
			stored    = '0;
			pair_ends++;
		endfunction

		function void note_request(logic [7:0] b, logic fin);
			logic [15:0] lim;
			logic [7:0]  hi;
			logic [7:0]  lo;
			requests++;
			step_q.delete();
			if (fin) begin
				if (pair_open) close_pair();
				emit(KIND_STRING, 8'h00, 1'b0, 1'b0);
				pair_open = 0;
				in_value  = 0;
				esc_phase = ESC_NONE;
				first_hex = '0;
				stored    = '0;
				string_ends++;
			end else begin
				lim = (pair_limit == 16'd0) ? 16'd1 : pair_limit;
				// cut the pair; this byte then opens the next one
				if (pair_open && stored >= lim) begin
					close_pair();
					cuts++;
				end
				if (!pair_open) begin
					pair_open = 1;
					in_value  = 0;
					esc_phase = ESC_NONE;
					stored    = '0;
				end
				if (b == CH_AMP) begin
					close_pair();
				end else if (b == CH_EQ) begin
					flush_escape();
					if (in_value) begin
						emit(KIND_RESTART, 8'h00, 1'b1, 1'b0);
						restarts++;
					end else begin
						in_value = 1;
					end
					stored++;
				end else begin
					stored++;
					case (esc_phase)
						ESC_PCT: begin
							first_hex = b;
							esc_phase = ESC_HEX;
						end
						ESC_HEX: begin
							hi = digit_value(first_hex);
							lo = digit_value(b);
							emit(KIND_DATA, {hi[3:0], 4'h0} | lo, in_value, 1'b0);
							esc_phase = ESC_NONE;
						end
						default: begin
							if (b == CH_PCT) esc_phase = ESC_PCT;
							else if (b == CH_PLUS) emit(KIND_DATA, CH_SPACE, in_value, 1'b0);
							else emit(KIND_DATA, b, in_value, 1'b0);
						end
					endcase
				end
			end
			// mark the final result of this request
			if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
			foreach (step_q[i]) expected_q.push_back(step_q[i]);
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] d, logic r, logic eq,
				logic l);
			token_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: kind %0d out_byte 0x%02h", k, d);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (k !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, k);
				errors++;
			end
			if (d !== want.data) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", want.data, d);
				errors++;
			end
			if (r !== want.role) begin
				$error("out_role: expected %0d, got %0d", want.role, r);
				errors++;
			end
			if (eq !== want.had_eq) begin
				$error("pair_had_equals: expected %0d, got %0d", want.had_eq, eq);
				errors++;
			end
			if (l !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	qsps_char_if chars_if();
	qsps_res_if  res_if();

	pair_scoreboard sb = new();
	char_req_t      char_queue[$];
	int             ready_mode;
	int             hold_cycles;
	int             cycle_count;
	int             limit_writes;

	query_string_pair_splitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.chars    (chars_if),
		.results  (res_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// note accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready)
				sb.check_result(res_if.kind, res_if.out_byte, res_if.out_role,
					res_if.pair_had_equals, res_if.last);
			if (chars_if.valid && chars_if.ready)
				sb.note_request(chars_if.in_byte, chars_if.in_end);
		end
	end

	// receiver: long hold-off first, then its own stall pattern
	initial begin
		int tick;
		tick = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				case (ready_mode)
					RDY_ALWAYS:  res_if.ready <= 1'b1;
					RDY_RANDOM:  res_if.ready <= ($urandom_range(0, 9) < 7);
					default:     res_if.ready <= ((tick % 5) >= 2);
				endcase
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("query_string_pair_splitter test failed");
		$finish;
	end

	function automatic void push_char(logic [7:0] c);
		char_queue.push_back(char_req_t'{code: c, fin: 1'b0});
	endfunction

	function automatic void push_end();
		char_queue.push_back(char_req_t'{code: 8'($urandom_range(0, 255)), fin: 1'b1});
	endfunction

	function automatic logic [7:0] pick_hex_digit();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return CH_ZERO + 8'(r);
		if (r < 16) return CH_UP_A + 8'(r - 10);
		return CH_LOW_A + 8'(r - 16);
	endfunction

	function automatic logic [7:0] pick_text_char();
		int r;
		r = $urandom_range(0, 35);
		if (r < 10) return CH_ZERO + 8'(r);
		return CH_LOW_A + 8'(r - 10);
	endfunction

	// one query string with random content, closed by a string end
	function automatic void add_query();
		int len;
		int pick;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 16);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				push_char(pick_text_char());
			end else if (pick < 60) begin
				push_char(CH_EQ);
			end else if (pick < 72) begin
				push_char(CH_AMP);
			end else if (pick < 77) begin
				push_char(CH_PLUS);
			end else if (pick < 88) begin
				push_char(CH_PCT);
				push_char(pick_hex_digit());
				push_char(pick_hex_digit());
			end else if (pick < 93) begin
				push_char(CH_PCT);
			end else begin
				push_char(8'($urandom_range(0, 255)));
			end
		end
		push_end();
	endfunction

	function automatic void build_queries(int n_items);
		while (char_queue.size() < n_items) add_query();
	endfunction

	// raw noise, with string ends sprinkled in
	function automatic void build_noise(int n_items);
		for (int i = 0; i < n_items; i++)
			char_queue.push_back(char_req_t'{code: 8'($urandom_range(0, 255)),
				fin: ($urandom_range(0, 9) == 0)});
	endfunction

	// offer queued requests in bursts; hold valid until each is taken
	task automatic send_chars(input int gap_max);
		int burst_left;
		int gap_left;
		burst_left = $urandom_range(1, 24);
		gap_left   = 0;
		while (char_queue.size() > 0) begin
			if (gap_left > 0) begin
				chars_if.valid   <= 1'b0;
				chars_if.in_byte <= 8'($urandom_range(0, 255));
				gap_left--;
			end else begin
				chars_if.valid   <= 1'b1;
				chars_if.in_byte <= char_queue[0].code;
				chars_if.in_end  <= char_queue[0].fin;
			end
			@(posedge clk);
			if (chars_if.valid && chars_if.ready) begin
				void'(char_queue.pop_front());
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
				end
			end
		end
		chars_if.valid <= 1'b0;
	endtask

	// let the last request reach the scoreboard, then wait for every result
	task automatic wait_drain();
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_limit(v);
		limit_writes++;
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int gap_max, input int mode);
		ready_mode = mode;
		send_chars(gap_max);
		wait_drain();
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		chars_if.valid   = 1'b0;
		chars_if.in_byte = '0;
		chars_if.in_end  = 1'b0;
		ready_mode       = RDY_RANDOM;
		hold_cycles      = 0;
		limit_writes     = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, plus, escapes, short escapes, empty pair, ends
		push_char("a");
		push_char(8'h00);
		push_char(8'hFF);
		push_char(CH_PLUS);
		push_char(CH_PCT);
		push_char("4");
		push_char("1");
		push_char(CH_EQ);
		push_char(CH_PCT);
		push_char(CH_PLUS);
		push_char(CH_PCT);
		push_char(CH_PCT);
		push_char("z");
		push_char(CH_EQ);
		push_char(CH_PCT);
		push_char(CH_AMP);
		push_char(CH_AMP);
		push_char("k");
		push_char(CH_PCT);
		push_end();
		push_end();
		run_phase(3, RDY_RANDOM);

		// directed cuts with a tiny limit, including an escape cut short
		write_limit(16'd2);
		push_char(CH_PCT);
		push_char("4");
		push_char(CH_AMP);
		push_char(CH_PCT);
		push_char("4");
		push_char("1");
		push_char(CH_EQ);
		push_char("a");
		push_char("b");
		push_char(CH_EQ);
		push_end();
		run_phase(2, RDY_PATTERN);

		build_queries(40);
		run_phase(4, RDY_RANDOM);

		// zero limit behaves as one
		write_limit(16'd0);
		build_queries(30);
		run_phase(3, RDY_PATTERN);

		write_limit(16'hFFFF);
		build_queries(70);
		run_phase(5, RDY_RANDOM);

		write_limit(16'd1);
		build_queries(30);
		run_phase(2, RDY_RANDOM);

		// long hold-off while the sender keeps offering
		write_limit(16'($urandom_range(3, 12)));
		build_queries(90);
		hold_cycles = 80;
		run_phase(0, RDY_RANDOM);

		write_limit(16'h8000 | 16'($urandom_range(0, 255)));
		build_noise(40);
		run_phase(3, RDY_PATTERN);

		// back-to-back with no stalls at all
		write_limit(MAX_PAIR_RESET);
		build_queries(80);
		run_phase(0, RDY_ALWAYS);

		$display("Run covered %0d requests and %0d results over %0d limit settings.",
			sb.requests, sb.results, limit_writes + 1);
		$display("Pair ends %0d (cuts %0d), value restarts %0d, string ends %0d, %0s %0d.",
			sb.pair_ends, sb.cuts, sb.restarts, sb.string_ends, "short escapes",
			sb.short_escapes);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("query_string_pair_splitter test passed");
		end else begin
			$display("query_string_pair_splitter test failed");
		end
		$finish;
	end

endmodule
